FILE: rtl/core/multi_slot_timer_engine_assert.svh
// ----------------------------------------------------------------------------
// Multi-slot timer engine assertion macros
// Shorthand for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_TIMER_ENGINE_ASSERT_SVH
`define MULTI_SLOT_TIMER_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSTE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSTE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mste_pkg.sv
// ----------------------------------------------------------------------------
// Multi-slot timer engine package
// Shared widths, defaults, operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package mste_pkg;

   localparam int OPC_W          = 2;
   localparam int ID_W           = 5;
   localparam int IVL_IN_W       = 32;
   localparam int TICK_OUT_W     = 32;
   localparam int CFG_W          = 5;
   localparam int SLOTS_RESET    = 16;
   localparam int NUM_SLOTS_DEF  = 16;
   localparam int TIME_WIDTH_DEF = 32;

   typedef enum logic [OPC_W-1:0] {
      OP_START  = 2'd0,
      OP_CHANGE = 2'd1,
      OP_STOP   = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic clr_scan;
      logic step_scan;
      logic tick_scan;
      logic tick_inc;
      logic alloc;
      logic change;
      logic stop;
      logic expire;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic alloc_end;
      logic slot_free;
      logic scan_done;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/core/mste_ram.sv
// ----------------------------------------------------------------------------
// Multi-slot timer engine RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mste_ram #(
   parameter int WIDTH = 2 * mste_pkg::TIME_WIDTH_DEF,
   parameter int DEPTH = mste_pkg::NUM_SLOTS_DEF
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/mste_ctrl.sv
// ----------------------------------------------------------------------------
// Multi-slot timer engine controller
// Sequences one operation at a time through the datapath.
// ----------------------------------------------------------------------------
module mste_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [mste_pkg::OPC_W-1:0] req_opcode,
   output logic                       req_ready,
   input  mste_pkg::stat_type         status,
   output mste_pkg::cmd_type          cmd
);

   import mste_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_CHANGE,
      S_STOP,
      S_TICK_SCAN,
      S_TICK_END,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.clr_scan = 1'b1;
               case (op_type'(req_opcode))
                  OP_START:  state_in = S_ALLOC;
                  OP_CHANGE: state_in = S_CHANGE;
                  OP_STOP:   state_in = S_STOP;
                  OP_TICK: begin
                     cmd.tick_inc = 1'b1;
                     state_in     = S_TICK_SCAN;
                  end
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_ALLOC: begin
            if (status.alloc_end) begin
               state_in = S_RESP;
            end else if (status.slot_free) begin
               cmd.alloc = 1'b1;
               state_in  = S_RESP;
            end else begin
               cmd.step_scan = 1'b1;
            end
         end
         S_CHANGE: begin
            cmd.change = 1'b1;
            state_in   = S_RESP;
         end
         S_STOP: begin
            cmd.stop = 1'b1;
            state_in = S_RESP;
         end
         S_TICK_SCAN: begin
            if (status.scan_done) begin
               state_in = S_TICK_END;
            end else begin
               cmd.tick_scan = 1'b1;
            end
         end
         S_TICK_END: begin
            cmd.expire = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

FILE: rtl/core/mste_dpath.sv
// ----------------------------------------------------------------------------
// Multi-slot timer engine datapath
// Slot state, tick counter, scan counter, timer RAM and output register.
// ----------------------------------------------------------------------------
module mste_dpath #(
   parameter int NUM_SLOTS  = mste_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = mste_pkg::TIME_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mste_pkg::cmd_type               cmd,
   output mste_pkg::stat_type              status,
   input  logic [mste_pkg::ID_W-1:0]       req_timer_id,
   input  logic [mste_pkg::IVL_IN_W-1:0]   req_interval,
   input  logic                            req_periodic,
   input  logic                            csr_wr_en,
   input  logic [mste_pkg::CFG_W-1:0]      csr_wr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mste_pkg::ID_W-1:0]       rsp_result_id,
   output logic                            rsp_expired,
   output logic [mste_pkg::TICK_OUT_W-1:0] rsp_tick_count,
   output logic                            rsp_any_active
);

   import mste_pkg::*;

   localparam int IDX_W = $clog2((NUM_SLOTS > 1) ? NUM_SLOTS : 2);
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam int CMP_A = (CNT_W > ID_W) ? CNT_W : ID_W;
   localparam int CMP_W = (CMP_A > CFG_W) ? CMP_A : CFG_W;
   localparam int MEM_W = 2 * TIME_WIDTH;

   logic [CFG_W-1:0]      slots_ff, slots_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [TIME_WIDTH-1:0] ivl_ff, ivl_in;
   logic                  per_ff, per_in;
   logic [TIME_WIDTH-1:0] tick_ff, tick_in;
   logic [NUM_SLOTS-1:0]  active_ff, active_in;
   logic [NUM_SLOTS-1:0]  periodic_ff, periodic_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [TIME_WIDTH-1:0] best_exp_ff, best_exp_in;
   logic [TIME_WIDTH-1:0] best_ivl_ff, best_ivl_in;
   logic [ID_W-1:0]       res_id_ff, res_id_in;
   logic                  res_exp_ff, res_exp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                  rsp_exp_ff, rsp_exp_in;
   logic [TICK_OUT_W-1:0] rsp_tick_ff, rsp_tick_in;
   logic                  rsp_act_ff, rsp_act_in;

   logic [IDX_W-1:0]      cnt_idx;
   logic [IDX_W-1:0]      id_idx;
   logic                  id_ok;
   logic                  hit;
   logic [TIME_WIDTH-1:0] addend;
   logic [TIME_WIDTH-1:0] sum;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [MEM_W-1:0]      wr_data;
   logic [MEM_W-1:0]      rd_data;
   logic [TIME_WIDTH-1:0] rd_exp;
   logic [TIME_WIDTH-1:0] rd_ivl;

   assign cnt_idx = cnt_ff[IDX_W-1:0];
   assign id_idx  = IDX_W'(CMP_W'(id_ff) - CMP_W'(1));
   assign id_ok   = (id_ff != '0) && (CMP_W'(id_ff) <= CMP_W'(NUM_SLOTS))
                    && active_ff[id_idx];
   assign hit     = best_found_ff && (tick_ff >= best_exp_ff);

   // One adder serves every re-arm: start and change use the request
   // interval, a periodic expiry uses the stored interval.
   assign addend  = cmd.expire ? best_ivl_ff : ivl_ff;
   assign sum     = tick_ff + addend;
   assign wr_data = {addend, sum};
   assign wr_en   = cmd.alloc || (cmd.change && id_ok)
                    || (cmd.expire && hit && periodic_ff[best_idx_ff]);
   assign wr_addr = cmd.alloc ? cnt_idx : (cmd.change ? id_idx : best_idx_ff);

   assign rd_exp = rd_data[TIME_WIDTH-1:0];
   assign rd_ivl = rd_data[MEM_W-1:TIME_WIDTH];

   mste_ram #(
      .WIDTH (MEM_W),
      .DEPTH (NUM_SLOTS)
   ) u_timer_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_idx),
      .rd_data (rd_data)
   );

   always_comb begin
      slots_in      = slots_ff;
      id_in         = id_ff;
      ivl_in        = ivl_ff;
      per_in        = per_ff;
      tick_in       = tick_ff;
      active_in     = active_ff;
      periodic_in   = periodic_ff;
      cnt_in        = cnt_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_exp_in   = best_exp_ff;
      best_ivl_in   = best_ivl_ff;
      res_id_in     = res_id_ff;
      res_exp_in    = res_exp_ff;

      if (csr_wr_en) begin
         slots_in = csr_wr_data;
      end

      if (cmd.load_req) begin
         id_in      = req_timer_id;
         ivl_in     = TIME_WIDTH'(req_interval);
         per_in     = req_periodic;
         res_id_in  = '0;
         res_exp_in = 1'b0;
      end

      if (cmd.clr_scan) begin
         cnt_in        = '0;
         best_found_in = 1'b0;
      end else if (cmd.step_scan || cmd.tick_scan) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (cmd.tick_inc) begin
         tick_in = tick_ff + TIME_WIDTH'(1);
      end

      // Running minimum over the RAM words read one per cycle; a strict
      // compare keeps the lowest slot on equal expiry.
      if (rd_vld_ff && active_ff[rd_idx_ff]
          && (!best_found_ff || (rd_exp < best_exp_ff))) begin
         best_found_in = 1'b1;
         best_idx_in   = rd_idx_ff;
         best_exp_in   = rd_exp;
         best_ivl_in   = rd_ivl;
      end

      if (cmd.alloc) begin
         active_in[cnt_idx]   = 1'b1;
         periodic_in[cnt_idx] = per_ff;
         res_id_in            = ID_W'(cnt_ff + CNT_W'(1));
      end

      if (cmd.change && id_ok) begin
         res_id_in = id_ff;
      end

      if (cmd.stop && id_ok) begin
         active_in[id_idx] = 1'b0;
         res_id_in         = id_ff;
      end

      if (cmd.expire && hit) begin
         if (!periodic_ff[best_idx_ff]) begin
            active_in[best_idx_ff] = 1'b0;
         end
         res_id_in  = ID_W'(CNT_W'(best_idx_ff) + CNT_W'(1));
         res_exp_in = 1'b1;
      end
   end

   assign rd_vld_in    = cmd.tick_scan;
   assign rd_idx_in    = cnt_idx;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_id_in    = cmd.out_load ? res_id_ff : rsp_id_ff;
   assign rsp_exp_in   = cmd.out_load ? res_exp_ff : rsp_exp_ff;
   assign rsp_tick_in  = cmd.out_load ? TICK_OUT_W'(tick_ff) : rsp_tick_ff;
   assign rsp_act_in   = cmd.out_load ? (|active_ff) : rsp_act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff      <= CFG_W'(SLOTS_RESET);
         tick_ff       <= '0;
         active_ff     <= '0;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slots_ff      <= slots_in;
         tick_ff       <= tick_in;
         active_ff     <= active_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      ivl_ff      <= ivl_in;
      per_ff      <= per_in;
      periodic_ff <= periodic_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_exp_ff <= best_exp_in;
      best_ivl_ff <= best_ivl_in;
      res_id_ff   <= res_id_in;
      res_exp_ff  <= res_exp_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_exp_ff  <= rsp_exp_in;
      rsp_tick_ff <= rsp_tick_in;
      rsp_act_ff  <= rsp_act_in;
   end

   assign status.alloc_end = (CMP_W'(cnt_ff) >= CMP_W'(slots_ff))
                             || (cnt_ff == CNT_W'(NUM_SLOTS));
   assign status.slot_free = !active_ff[cnt_idx];
   assign status.scan_done = (cnt_ff == CNT_W'(NUM_SLOTS));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_expired    = rsp_exp_ff;
   assign rsp_tick_count = rsp_tick_ff;
   assign rsp_any_active = rsp_act_ff;

endmodule

FILE: rtl/core/multi_slot_timer_engine.sv
// ----------------------------------------------------------------------------
// Multi-slot timer engine
// Pool of one-shot and periodic timer slots driven by start, change, stop
// and tick requests, one response word per request word.
// ----------------------------------------------------------------------------
// The engine handles one request word at a time and answers each with exactly
// one response word. A start walks the slot flags one per cycle from slot 1 in
// search of a free one, up to slots_in_use limited to NUM_SLOTS; a change or a
// stop needs no search. A tick searches for the earliest expiry by reading the
// interval/expiry RAM through its single read port, one slot per cycle. A new
// request word is taken while the previous response word still waits in the
// output register, so a stalled consumer only holds the engine once a second
// response is ready. Both the tick counter and the stored expiry times wrap at
// TIME_WIDTH bits and are compared as plain unsigned numbers, so a timer armed
// across the wrap may fire early.
// ----------------------------------------------------------------------------
module multi_slot_timer_engine #(
   parameter int NUM_SLOTS  = mste_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = mste_pkg::TIME_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mste_pkg::OPC_W-1:0]      req_opcode,
   input  logic [mste_pkg::ID_W-1:0]       req_timer_id,
   input  logic [mste_pkg::IVL_IN_W-1:0]   req_interval,
   input  logic                            req_periodic,
   // Response channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mste_pkg::ID_W-1:0]       rsp_result_id,
   output logic                            rsp_expired,
   output logic [mste_pkg::TICK_OUT_W-1:0] rsp_tick_count,
   output logic                            rsp_any_active,
   // Configuration: number of slots a start may allocate from.
   input  logic                            csr_wr_en,
   input  logic [mste_pkg::CFG_W-1:0]      csr_wr_data
);

   import mste_pkg::*;

   `include "multi_slot_timer_engine_assert.svh"

   cmd_type  cmd;
   stat_type status;

   // The controller decides what happens in each cycle; it never touches the
   // slot state itself.
   mste_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the slot flags, the tick counter, the timer RAM and
   // the response register.
   mste_dpath #(
      .NUM_SLOTS  (NUM_SLOTS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_timer_id   (req_timer_id),
      .req_interval   (req_interval),
      .req_periodic   (req_periodic),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_id  (rsp_result_id),
      .rsp_expired    (rsp_expired),
      .rsp_tick_count (rsp_tick_count),
      .rsp_any_active (rsp_any_active)
   );

   // Only one operation is in flight, so ready must drop right after a word
   // is taken.
   `MSTE_ASSERT_NEXT(a_single_in_flight, req_valid && req_ready, !req_ready, "ready after accept")

   // At most one RAM or slot update is commanded in any cycle.
   `MSTE_ASSERT_SAME(a_one_update, 1'b1,
      $onehot0({cmd.alloc, cmd.change, cmd.stop, cmd.expire}), "update clash")

   // A response is never loaded over one that the consumer has not taken.
   `MSTE_ASSERT_SAME(a_no_overwrite, cmd.out_load, !rsp_valid || rsp_ready, "response overwritten")

   // Request data is only loaded in a cycle in which a request word is taken.
   `MSTE_ASSERT_SAME(a_load_when_ready, cmd.load_req, req_ready && req_valid, "load without accept")

endmodule
